### rtl/nalf_pkg.sv
// nalf_pkg: shared types and constants for the nal unit filter
// beat payload structs, queue job record, nal type codes
// no dependencies
`default_nettype none

package nalf_pkg;

  localparam int MAX_PREFIX_BYTES_DEF = 4;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam logic [2:0] LEN_SIZE_RESET = 3'd4;

  // nal unit type codes
  localparam logic [4:0] NAL_SLICE  = 5'd1;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_AUD    = 5'd9;
  localparam logic [4:0] NAL_FILLER = 5'd12;
  localparam logic [4:0] NAL_AUX    = 5'd19;

  // primary_pic_type codes
  localparam logic [3:0] PIC_I        = 4'd0;
  localparam logic [3:0] PIC_IP       = 4'd1;
  localparam logic [3:0] PIC_IPB      = 4'd2;
  localparam logic [3:0] PIC_SI       = 4'd3;
  localparam logic [3:0] PIC_SI_SP    = 4'd4;
  localparam logic [3:0] PIC_I_SI     = 4'd5;
  localparam logic [3:0] PIC_IP_SPSI  = 4'd6;
  localparam logic [3:0] PIC_ALL      = 4'd7;
  localparam logic [3:0] PIC_NONE     = 4'd8;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  out_byte;
    logic        run_end;
    logic        aud_seen;
    logic [3:0]  picture_type;
    logic [31:0] kept_length;
    logic        status;
  } out_item_t;

  // work handed from front to back, prefix bytes travel beside it
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic        has_sum;
    logic        aud;
    logic [3:0]  pic;
    logic [31:0] len;
    logic        status;
  } job_t;

endpackage

`default_nettype wire

### rtl/nalf_fifo.sv
// nalf_fifo: small show-ahead queue between parser front and result back
// generic width and depth, flip-flop storage
// no package dependencies
`default_nettype none

module nalf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_push;
  logic do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/nalf_front.sv
// nalf_front: accepts stream beats, parses prefixes, unit types and slice headers
// emits one job per beat that yields results; holds the length_size register
// depends on nalf_pkg
`default_nettype none

module nalf_front #(
  parameter int MAX_PREFIX_BYTES = nalf_pkg::MAX_PREFIX_BYTES_DEF,
  localparam int PCW = $clog2(MAX_PREFIX_BYTES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire nalf_pkg::in_item_t            in_data,
  input  wire logic                          q_full,
  output logic                               push,
  output logic [MAX_PREFIX_BYTES*8-1:0]      pre_vec,
  output logic [PCW-1:0]                     pre_cnt,
  output nalf_pkg::job_t                     job
);

  import nalf_pkg::*;

  localparam int IW = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'b001,
    PH_TYPE   = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_SKIP = 3'b010,
    G_TYPE = 3'b100
  } gstage_t;

  typedef struct packed {
    gstage_t    stage;
    logic [5:0] zr;
    logic [5:0] sl;
    logic [4:0] sv;
    logic [4:0] types;
  } gol_t;

  function automatic gol_t gol_done(gol_t g);
    gol_t       r;
    logic [5:0] v;
    r = g;
    v = '0;
    if (g.stage == G_SKIP) begin
      r.stage = G_TYPE;
      r.zr    = '0;
      r.sv    = '0;
    end else begin
      if (g.zr <= 6'd3) begin
        v = ((6'd1 << g.zr) - 6'd1) + {1'b0, g.sv};
        if (v >= 6'd5) v = v - 6'd5;
        if (v < 6'd5) r.types = r.types | (5'd1 << v[2:0]);
      end
      r.stage = G_IDLE;
    end
    return r;
  endfunction

  function automatic gol_t gol_bit(gol_t g, logic b);
    gol_t r;
    r = g;
    if (g.stage == G_SKIP || g.stage == G_TYPE) begin
      if (g.sl != '0) begin
        r.sv = {g.sv[3:0], b};
        r.sl = g.sl - 6'd1;
        if (r.sl == '0) r = gol_done(r);
      end else if (!b) begin
        if (g.zr >= 6'd31) r.stage = G_IDLE;
        else r.zr = g.zr + 6'd1;
      end else if (g.zr == '0) begin
        r = gol_done(r);
      end else begin
        r.sl = g.zr;
        r.sv = '0;
      end
    end
    return r;
  endfunction

  // one byte, msb first
  function automatic gol_t gol_byte(gol_t g, logic [7:0] d);
    gol_t r;
    r = g;
    for (int s = 7; s >= 0; s--) begin
      r = gol_bit(r, d[3'(s)]);
    end
    return r;
  endfunction

  function automatic logic [3:0] pic_of(logic [4:0] f);
    logic [3:0] p;
    priority if (f[1]) p = (f[3] || f[4]) ? PIC_ALL : PIC_IPB;
    else if (f[0])     p = (f[3] || f[4]) ? PIC_IP_SPSI : PIC_IP;
    else if (f[2])     p = f[4] ? PIC_I_SI : PIC_I;
    else if (f[4])     p = f[3] ? PIC_SI_SP : PIC_SI;
    else               p = PIC_NONE;
    return p;
  endfunction

  // registers
  logic [2:0]  length_size;
  phase_t      phase, phase_next;
  logic [PCW-1:0] pc, pc_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        keep_unit, keep_unit_next;
  gol_t        gol, gol_next;
  logic        aud, aud_next;
  logic [31:0] out_count, out_count_next;
  logic        fail, fail_next;
  logic [7:0]  pf [MAX_PREFIX_BYTES];

  logic        in_fire;
  logic [2:0]  eff_len;
  logic [PCW-1:0] pc_inc;
  logic [31:0] bl_base;
  logic [31:0] bl_dec;
  logic [32:0] cnt_sum;
  logic [4:0]  nal_type;
  logic        bad;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign nal_type = in_data.in_byte[4:0];
  assign pc_inc   = pc + 1'b1;
  assign bl_base  = (pc == '0) ? '0 : bytes_left;
  assign bl_dec   = bytes_left - 32'd1;

  always_comb begin
    if (length_size == 3'd0) eff_len = 3'd1;
    else if (length_size > 3'(MAX_PREFIX_BYTES)) eff_len = 3'(MAX_PREFIX_BYTES);
    else eff_len = length_size;
  end

  always_comb begin
    for (int i = 0; i < MAX_PREFIX_BYTES; i++) begin
      pre_vec[i*8 +: 8] = pf[i];
    end
  end

  always_comb begin
    phase_next      = phase;
    pc_next         = pc;
    bytes_left_next = bytes_left;
    keep_unit_next  = keep_unit;
    gol_next        = gol;
    aud_next        = aud;
    out_count_next  = out_count;
    fail_next       = fail;
    push            = 1'b0;
    pre_cnt         = '0;
    job             = '0;
    cnt_sum         = '0;
    bad             = 1'b0;

    if (in_fire) begin
      if (!fail) begin
        unique case (phase)
          PH_TYPE: begin
            keep_unit_next = (nal_type != NAL_FILLER);
            gol_next.stage = G_IDLE;
            if (nal_type != NAL_FILLER) begin
              push          = 1'b1;
              pre_cnt       = pc;
              job.has_data  = 1'b1;
              job.data_byte = in_data.in_byte;
              cnt_sum       = {1'b0, out_count} + 33'(pc_inc);
              out_count_next = cnt_sum[32] ? '1 : cnt_sum[31:0];
              if (nal_type == NAL_SLICE || nal_type == NAL_IDR || nal_type == NAL_AUX) begin
                gol_next.stage = G_SKIP;
                gol_next.zr    = '0;
                gol_next.sl    = '0;
                gol_next.sv    = '0;
              end
              if (nal_type == NAL_AUD) aud_next = 1'b1;
            end
            bytes_left_next = bl_dec;
            if (bl_dec == '0) begin
              phase_next     = PH_PREFIX;
              pc_next        = '0;
              gol_next.stage = G_IDLE;
            end else begin
              phase_next = PH_BODY;
            end
          end
          PH_BODY: begin
            if (keep_unit) begin
              push          = 1'b1;
              job.has_data  = 1'b1;
              job.data_byte = in_data.in_byte;
              out_count_next = (out_count == '1) ? out_count : out_count + 32'd1;
            end
            gol_next        = gol_byte(gol, in_data.in_byte);
            bytes_left_next = bl_dec;
            if (bl_dec == '0) begin
              phase_next     = PH_PREFIX;
              pc_next        = '0;
              gol_next.stage = G_IDLE;
            end
          end
          PH_PREFIX: begin
            pc_next         = pc_inc;
            bytes_left_next = {bl_base[23:0], in_data.in_byte};
            if (3'(pc_inc) >= eff_len) begin
              if (bytes_left_next == '0) fail_next = 1'b1;
              else phase_next = PH_TYPE;
            end
          end
          default: begin
            phase_next = PH_PREFIX;
          end
        endcase
      end

      if (in_data.last_byte) begin
        bad        = fail_next || (phase_next != PH_PREFIX) || (pc_next != '0);
        push       = 1'b1;
        job.has_sum = 1'b1;
        job.aud    = bad ? 1'b0 : aud_next;
        job.pic    = bad ? PIC_NONE : pic_of(gol_next.types);
        job.len    = bad ? '0 : out_count_next;
        job.status = bad;
        // per-buffer state back to reset
        phase_next      = PH_PREFIX;
        pc_next         = '0;
        bytes_left_next = '0;
        keep_unit_next  = 1'b0;
        gol_next        = '{stage: G_IDLE, zr: '0, sl: '0, sv: '0, types: '0};
        aud_next        = 1'b0;
        out_count_next  = '0;
        fail_next       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !fail && phase == PH_PREFIX) begin
      pf[pc[IW-1:0]] <= in_data.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_size <= LEN_SIZE_RESET;
      phase       <= PH_PREFIX;
      pc          <= '0;
      bytes_left  <= '0;
      keep_unit   <= 1'b0;
      gol         <= '{stage: G_IDLE, zr: '0, sl: '0, sv: '0, types: '0};
      aud         <= 1'b0;
      out_count   <= '0;
      fail        <= 1'b0;
    end else begin
      if (cfg_we) length_size <= cfg_wdata;
      phase      <= phase_next;
      pc         <= pc_next;
      bytes_left <= bytes_left_next;
      keep_unit  <= keep_unit_next;
      gol        <= gol_next;
      aud        <= aud_next;
      out_count  <= out_count_next;
      fail       <= fail_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_byte |=> phase == PH_PREFIX && pc == '0 && !fail
      && out_count == '0)
    else $error("buffer state not cleared after last beat");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_fail_silent: assert property (@(posedge clk) disable iff (rst)
    fail && in_fire && !in_data.last_byte |-> !push)
    else $error("result produced after zero-length failure");

endmodule

`default_nettype wire

### rtl/nalf_back.sv
// nalf_back: expands queued jobs into result beats, one per cycle while out_ready allows
// prefix bytes, then the type or body byte, then the summary
// depends on nalf_pkg
`default_nettype none

module nalf_back #(
  parameter int MAX_PREFIX_BYTES = nalf_pkg::MAX_PREFIX_BYTES_DEF,
  localparam int PCW = $clog2(MAX_PREFIX_BYTES + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         head_valid,
  input  wire logic [MAX_PREFIX_BYTES*8-1:0] pre_vec,
  input  wire logic [PCW-1:0]               pre_cnt,
  input  wire nalf_pkg::job_t               job,
  output logic                              pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output nalf_pkg::out_item_t               out_data
);

  import nalf_pkg::*;

  localparam int NW = $clog2(MAX_PREFIX_BYTES + 3);
  localparam int IW = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;

  logic [NW-1:0] idx;
  logic [NW-1:0] n_res;
  logic          last_res;
  logic          load;
  logic [7:0]    pre_arr [2**IW];
  out_item_t     res;

  always_comb begin
    for (int i = 0; i < 2**IW; i++) begin
      pre_arr[i] = (i < MAX_PREFIX_BYTES) ? pre_vec[i*8 +: 8] : 8'h00;
    end
  end

  assign n_res    = NW'(pre_cnt) + NW'(job.has_data) + NW'(job.has_sum);
  assign last_res = (idx == n_res - 1'b1);
  assign load     = head_valid && (!out_valid || out_ready);
  assign pop      = load && last_res;

  always_comb begin
    res         = '0;
    res.run_end = last_res;
    if (idx < NW'(pre_cnt)) begin
      res.out_kind = KIND_DATA;
      res.out_byte = pre_arr[idx[IW-1:0]];
    end else if (idx == NW'(pre_cnt) && job.has_data) begin
      res.out_kind = KIND_DATA;
      res.out_byte = job.data_byte;
    end else begin
      res.out_kind     = KIND_SUMMARY;
      res.aud_seen     = job.aud;
      res.picture_type = job.pic;
      res.kept_length  = job.len;
      res.status       = job.status;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_res ? '0 : idx + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_sum_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == KIND_SUMMARY |-> out_data.run_end)
    else $error("summary beat not marked as run end");

  a_fail_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == KIND_SUMMARY && out_data.status
      |-> out_data.picture_type == PIC_NONE && out_data.kept_length == '0
        && !out_data.aud_seen)
    else $error("failure summary carries data");

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == KIND_DATA
      |-> out_data.kept_length == '0 && out_data.picture_type == '0
        && !out_data.status && !out_data.aud_seen)
    else $error("data beat carries summary fields");

endmodule

`default_nettype wire

### rtl/nal_unit_filter_and_pic_type.sv
// length-prefixed nal unit filter with primary picture type summary
// the first result of an accepted beat passes the job queue, then the registered output beat
// throughput: one input beat per cycle while the queue has room, one result out per cycle
//   when out_ready allows; a type byte with k held prefix bytes yields k+1 results (+1 with summary)
// a QUEUE_DEPTH job queue between parser and result sequencer absorbs those bursts
// reset: synchronous rst clears parser, queue and output; length_size returns to 4
`default_nettype none

module nal_unit_filter_and_pic_type #(
  parameter int MAX_PREFIX_BYTES = nalf_pkg::MAX_PREFIX_BYTES_DEF,
  parameter int QUEUE_DEPTH      = nalf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire nalf_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output nalf_pkg::out_item_t       out_data
);

  import nalf_pkg::*;

  localparam int PCW   = $clog2(MAX_PREFIX_BYTES + 1);
  localparam int PVW   = MAX_PREFIX_BYTES * 8;
  localparam int JW    = $bits(job_t);
  localparam int QW    = PVW + PCW + JW;

  // front side of the queue
  logic           push;
  logic [PVW-1:0] f_pre_vec;
  logic [PCW-1:0] f_pre_cnt;
  job_t           f_job;

  // back side of the queue
  logic           pop;
  logic           q_full;
  logic           q_empty;
  logic [QW-1:0]  q_dout;
  logic [PVW-1:0] b_pre_vec;
  logic [PCW-1:0] b_pre_cnt;
  job_t           b_job;

  // parser: prefix collection, unit type, slice header exp-golomb decode
  nalf_front #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .pre_vec  (f_pre_vec),
    .pre_cnt  (f_pre_cnt),
    .job      (f_job)
  );

  // job queue, one entry per beat that yields results
  nalf_fifo #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({f_pre_vec, f_pre_cnt, f_job}),
    .pop  (pop),
    .dout (q_dout),
    .full (q_full),
    .empty(q_empty)
  );

  assign {b_pre_vec, b_pre_cnt, b_job} = q_dout;

  // result sequencer with registered output beat
  nalf_back #(
    .MAX_PREFIX_BYTES(MAX_PREFIX_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(!q_empty),
    .pre_vec   (b_pre_vec),
    .pre_cnt   (b_pre_cnt),
    .job       (b_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
